// File: sv/rc4_pkg.sv
// shared types and constants for the rc4 stream cipher
package rc4_pkg;

  localparam int PERM_W     = 8;
  localparam int PERM_DEPTH = 256;

  // request command codes
  localparam logic CMD_KEY = 1'b0;
  localparam logic CMD_MSG = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [PERM_W-1:0] value;
    logic             key_last;
  } req_t;

  typedef struct packed {
    logic [PERM_W-1:0] out_byte;
    logic [PERM_W-1:0] keystream;
    logic              not_keyed;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_KS_RD,
    ST_KS_J,
    ST_KS_WI,
    ST_KS_WJ,
    ST_GEN_J,
    ST_GEN_T,
    ST_GEN_OUT,
    ST_PASS
  } state_t;

  // permutation read address source
  typedef enum logic [2:0] {
    PR_I,
    PR_INC,
    PR_JKEY,
    PR_JMSG,
    PR_TNEW,
    PR_TREG
  } pr_sel_t;

  // permutation write source
  typedef enum logic [1:0] {
    PW_NONE,
    PW_IDENT,
    PW_I_RD,
    PW_J_S
  } pw_sel_t;

  typedef struct packed {
    logic    key_wr;
    logic    msg_ld;
    logic    i_clr;
    logic    i_inc;
    logic    j_clr;
    logic    j_ld;
    logic    kidx_clr;
    logic    kidx_step;
    logic    s_ld;
    logic    t_ld;
    logic    sched_done;
    logic    out_ks;
    logic    out_pass;
    pr_sel_t pr_sel;
    pw_sel_t pw_sel;
  } cmd_t;

  typedef struct packed {
    logic keyed;
    logic i_last;
    logic slot_free;
  } sts_t;

endpackage

// File: sv/rc4_ctrl.sv
// sequencer for key loading, key schedule and keystream generation
module rc4_ctrl import rc4_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (req.cmd == CMD_KEY) begin
            if (req.key_last) state_next = ST_INIT;
          end else if (sts.keyed) begin
            state_next = ST_GEN_J;
          end else begin
            state_next = ST_PASS;
          end
        end
      end
      ST_INIT:    if (sts.i_last) state_next = ST_KS_RD;
      ST_KS_RD:   state_next = ST_KS_J;
      ST_KS_J:    state_next = ST_KS_WI;
      ST_KS_WI:   state_next = ST_KS_WJ;
      ST_KS_WJ:   state_next = sts.i_last ? ST_IDLE : ST_KS_RD;
      ST_GEN_J:   state_next = ST_GEN_T;
      ST_GEN_T:   state_next = ST_GEN_OUT;
      ST_GEN_OUT: if (sts.slot_free) state_next = ST_IDLE;
      ST_PASS:    if (sts.slot_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.pr_sel = PR_INC;
    cmd.pw_sel = PW_NONE;
    req_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        // nothing is taken while reset is held
        req_ready = !rst;
        if (req_valid && !rst) begin
          if (req.cmd == CMD_KEY) begin
            cmd.key_wr = 1'b1;
            if (req.key_last) begin
              cmd.i_clr    = 1'b1;
              cmd.j_clr    = 1'b1;
              cmd.kidx_clr = 1'b1;
            end
          end else begin
            cmd.msg_ld = 1'b1;
            // first read of the generation step goes out with the request
            if (sts.keyed) cmd.i_inc = 1'b1;
          end
        end
      end
      ST_INIT: begin
        cmd.pw_sel = PW_IDENT;
        cmd.i_inc  = 1'b1;
      end
      ST_KS_RD: begin
        cmd.pr_sel = PR_I;
      end
      ST_KS_J: begin
        cmd.pr_sel = PR_JKEY;
        cmd.j_ld   = 1'b1;
        cmd.s_ld   = 1'b1;
      end
      ST_KS_WI: begin
        cmd.pw_sel = PW_I_RD;
      end
      ST_KS_WJ: begin
        cmd.pw_sel    = PW_J_S;
        cmd.i_inc     = 1'b1;
        cmd.kidx_step = 1'b1;
        if (sts.i_last) cmd.sched_done = 1'b1;
      end
      ST_GEN_J: begin
        cmd.pr_sel = PR_JMSG;
        cmd.j_ld   = 1'b1;
        cmd.s_ld   = 1'b1;
      end
      ST_GEN_T: begin
        cmd.pr_sel = PR_TNEW;
        cmd.pw_sel = PW_I_RD;
        cmd.t_ld   = 1'b1;
      end
      ST_GEN_OUT: begin
        cmd.pr_sel = PR_TREG;
        cmd.pw_sel = PW_J_S;
        if (sts.slot_free) cmd.out_ks = 1'b1;
      end
      ST_PASS: begin
        if (sts.slot_free) cmd.out_pass = 1'b1;
      end
      default: begin
        cmd.pr_sel = PR_INC;
      end
    endcase
  end

endmodule

// File: sv/rc4_dp.sv
// permutation and key memories, stream indices and result register
module rc4_dp import rc4_pkg::*; #(
  parameter int KEY_DEPTH = 256
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  cmd_t cmd,
  output sts_t sts,
  output res_t res,
  output logic res_valid,
  input  logic res_ready
);

  localparam int KIDX_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int KCNT_W = $clog2(KEY_DEPTH + 1);

  logic [PERM_W-1:0] perm [PERM_DEPTH];
  logic [PERM_W-1:0] key_mem [KEY_DEPTH];

  logic [PERM_W-1:0] i;
  logic [PERM_W-1:0] j;
  logic [PERM_W-1:0] s_val;
  logic [PERM_W-1:0] sj_val;
  logic [PERM_W-1:0] t_idx;
  logic [PERM_W-1:0] msg;
  logic [PERM_W-1:0] rd_data;
  logic [PERM_W-1:0] key_data;
  logic [KIDX_W-1:0] kidx;
  logic [KCNT_W-1:0] key_count;
  logic              keyed;

  logic [PERM_W-1:0] praddr;
  logic              pw_en;
  logic [PERM_W-1:0] pw_addr;
  logic [PERM_W-1:0] pw_data;
  logic [PERM_W-1:0] ks_val;
  logic              key_room;
  logic              slot_free;
  logic              kidx_wrap;

  assign key_room  = key_count < KCNT_W'(KEY_DEPTH);
  assign slot_free = !res_valid || res_ready;
  assign kidx_wrap = KCNT_W'(kidx) == (key_count - KCNT_W'(1));

  always_comb begin
    case (cmd.pr_sel)
      PR_I:    praddr = i;
      PR_INC:  praddr = i + PERM_W'(1);
      PR_JKEY: praddr = j + rd_data + key_data;
      PR_JMSG: praddr = j + rd_data;
      PR_TNEW: praddr = s_val + rd_data;
      PR_TREG: praddr = t_idx;
      default: praddr = i;
    endcase
  end

  always_comb begin
    pw_en   = 1'b0;
    pw_addr = i;
    pw_data = rd_data;
    case (cmd.pw_sel)
      PW_NONE:  pw_en = 1'b0;
      PW_IDENT: begin
        pw_en   = 1'b1;
        pw_data = i;
      end
      PW_I_RD:  pw_en = 1'b1;
      PW_J_S:   begin
        pw_en   = 1'b1;
        pw_addr = j;
        pw_data = s_val;
      end
      default:  pw_en = 1'b0;
    endcase
  end

  // after the swap, perm[j] holds s and perm[i] holds the old perm[j]
  always_comb begin
    if (t_idx == j) begin
      ks_val = s_val;
    end else if (t_idx == i) begin
      ks_val = sj_val;
    end else begin
      ks_val = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (pw_en) perm[pw_addr] <= pw_data;
    rd_data <= perm[praddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.key_wr && key_room) key_mem[key_count[KIDX_W-1:0]] <= req.value;
    key_data <= key_mem[kidx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i         <= '0;
      j         <= '0;
      key_count <= '0;
      keyed     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.i_clr) begin
        i <= '0;
      end else if (cmd.i_inc) begin
        i <= i + PERM_W'(1);
      end
      if (cmd.j_clr || cmd.sched_done) begin
        j <= '0;
      end else if (cmd.j_ld) begin
        j <= praddr;
      end
      if (cmd.sched_done) begin
        key_count <= '0;
      end else if (cmd.key_wr && key_room) begin
        key_count <= key_count + KCNT_W'(1);
      end
      if (cmd.sched_done) keyed <= 1'b1;
      if (cmd.out_ks || cmd.out_pass) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.msg_ld) msg <= req.value;
    if (cmd.s_ld) s_val <= rd_data;
    if (cmd.t_ld) begin
      t_idx  <= praddr;
      sj_val <= rd_data;
    end
    if (cmd.kidx_clr) begin
      kidx <= '0;
    end else if (cmd.kidx_step) begin
      kidx <= kidx_wrap ? '0 : kidx + KIDX_W'(1);
    end
    if (cmd.out_ks) begin
      res.out_byte  <= msg ^ ks_val;
      res.keystream <= ks_val;
      res.not_keyed <= 1'b0;
    end else if (cmd.out_pass) begin
      res.out_byte  <= msg;
      res.keystream <= '0;
      res.not_keyed <= 1'b1;
    end
  end

  assign sts.keyed     = keyed;
  assign sts.i_last    = i == {PERM_W{1'b1}};
  assign sts.slot_free = slot_free;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_ks || cmd.out_pass) |-> slot_free)
    else $error("result register loaded while holding an untaken result");

  a_key_count_range: assert property (@(posedge clk) disable iff (rst)
    key_count <= KCNT_W'(KEY_DEPTH))
    else $error("key byte count beyond key store depth");

  a_sched_end: assert property (@(posedge clk) disable iff (rst)
    cmd.sched_done |=> (i == '0) && (j == '0) && keyed && (key_count == '0))
    else $error("key schedule did not leave clean stream state");

  a_ks_keyed: assert property (@(posedge clk) disable iff (rst)
    cmd.out_ks |-> keyed)
    else $error("keystream result produced without a key");

endmodule

// File: sv/rc4_stream_cipher.sv
// rc4 stream cipher top level: sequencer plus permutation datapath
//
//  channel  handshake              payload   direction
//  request  req_valid / req_ready  req       in:  cmd, value, key_last
//  result   res_valid / res_ready  res       out: out_byte, keystream, not_keyed
//
// key byte request: no result; a key byte marked last then keeps the block busy
//   with the identity fill of 256 entries, then 256 swaps (read i, read j, write i, write j)
// message request with a key: steps set by the one read port and one write port of the
//   permutation memory (read i, read j, write i and read the output index, write j)
// message request before any key: passed through with not_keyed set
// reset (rst, synchronous) clears stream indices i and j, key count, keyed flag and
//   result valid; memories are not cleared, each is written before it is read
// a result waits in the output register while res_ready is low; a new
//   request is still taken, its result is held at the last step until free
module rc4_stream_cipher import rc4_pkg::*; #(
  parameter int KEY_DEPTH = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  rc4_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .sts       (sts),
    .cmd       (cmd)
  );

  rc4_dp #(
    .KEY_DEPTH (KEY_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready)
  );

endmodule

// File: tb/rc4_stream_cipher_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the rc4 stream cipher: directed table then random traffic
module rc4_stream_cipher_test;
  import rc4_pkg::*;

  // run bounds
  localparam int LIMIT_CYCLES = 1000000;
  localparam int RANDOM_ITEMS = 1150;
  // a marked key byte keeps the block busy for the whole key schedule
  localparam int TAIL_CYCLES  = 1400;
  localparam int KEY_MAX      = 256;
  localparam int MAX_PRINTS   = 20;

  localparam res_t NO_RES = '0;

  // one directed row: request, whether the result is typed in, and that result
  typedef struct packed {
    req_t rq;
    logic typed;
    res_t want;
  } dir_row_t;

  // directed table: typed results only for bytes that pass through before any key
  localparam int DIR_ROWS = 20;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // message before any key, low extreme
    {CMD_MSG, 8'h00, 1'b0, 1'b1, 8'h00, 8'h00, 1'b1},
    // high extreme, key_last ignored on a message
    {CMD_MSG, 8'hFF, 1'b1, 1'b1, 8'hFF, 8'h00, 1'b1},
    // unmarked key byte does not make the block keyed
    {CMD_KEY, 8'hFF, 1'b0, 1'b0, NO_RES},
    {CMD_MSG, 8'hA5, 1'b0, 1'b1, 8'hA5, 8'h00, 1'b1},
    // two byte key ff 00
    {CMD_KEY, 8'h00, 1'b1, 1'b0, NO_RES},
    {CMD_MSG, 8'h00, 1'b0, 1'b0, NO_RES},
    {CMD_MSG, 8'hFF, 1'b1, 1'b0, NO_RES},
    // single byte key
    {CMD_KEY, 8'hFF, 1'b1, 1'b0, NO_RES},
    {CMD_MSG, 8'h00, 1'b0, 1'b0, NO_RES},
    {CMD_MSG, 8'hFF, 1'b0, 1'b0, NO_RES},
    // partial new key must not disturb the running stream
    {CMD_KEY, 8'h12, 1'b0, 1'b0, NO_RES},
    {CMD_MSG, 8'h5A, 1'b0, 1'b0, NO_RES},
    {CMD_KEY, 8'h34, 1'b1, 1'b0, NO_RES},
    {CMD_MSG, 8'h3C, 1'b1, 1'b0, NO_RES},
    // ascii key "Key", message "Pla"
    {CMD_KEY, 8'h4B, 1'b0, 1'b0, NO_RES},
    {CMD_KEY, 8'h65, 1'b0, 1'b0, NO_RES},
    {CMD_KEY, 8'h79, 1'b1, 1'b0, NO_RES},
    {CMD_MSG, 8'h50, 1'b0, 1'b0, NO_RES},
    {CMD_MSG, 8'h6C, 1'b0, 1'b0, NO_RES},
    {CMD_MSG, 8'h61, 1'b0, 1'b0, NO_RES}
  };

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic res_valid;
  logic res_ready;
  res_t res;

  rc4_stream_cipher #(.KEY_DEPTH(KEY_MAX)) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // cipher state as the testbench sees it
  logic [7:0]  sbox [256];
  logic [7:0]  key_bytes [256];
  int unsigned key_len;
  logic [7:0]  idx_i;
  logic [7:0]  idx_j;
  bit          have_key;

  // cipher results still to come, oldest first
  res_t cipher_q [$];
  res_t want_res;

  int mismatches;
  int results_seen;
  int pass_results;
  int schedules;
  int sent;
  // generator side: key bytes since the last mark, and random requests that count
  int gen_keys;
  int stim_count;
  bit send_steady;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // identity fill, then 256 swaps with the stored key repeated
  function automatic void run_key_schedule();
    int unsigned len;
    logic [7:0] j;
    logic [7:0] t;
    len = (key_len == 0) ? 1 : ((key_len > 256) ? 256 : key_len);
    for (int n = 0; n < 256; n++) sbox[n] = n[7:0];
    j = 8'h00;
    for (int n = 0; n < 256; n++) begin
      j = j + sbox[n] + key_bytes[n % len];
      t = sbox[n];
      sbox[n] = sbox[j];
      sbox[j] = t;
    end
    idx_i = 8'h00;
    idx_j = 8'h00;
    have_key = 1'b1;
    key_len = 0;
    schedules++;
  endfunction

  // advance the cipher by one request; returns 1 when it yields a result
  function automatic bit cipher_step(input req_t r, output res_t e);
    logic [7:0] t;
    logic [7:0] ks;
    e = '0;
    if (r.cmd == CMD_KEY) begin
      // bytes past the key store are dropped, a mark still schedules
      if (key_len < KEY_MAX) begin
        key_bytes[key_len] = r.value;
        key_len++;
      end
      if (r.key_last) run_key_schedule();
      return 1'b0;
    end
    if (!have_key) begin
      e.out_byte  = r.value;
      e.not_keyed = 1'b1;
      return 1'b1;
    end
    idx_i = idx_i + 8'd1;
    idx_j = idx_j + sbox[idx_i];
    t = sbox[idx_i];
    sbox[idx_i] = sbox[idx_j];
    sbox[idx_j] = t;
    t = sbox[idx_i] + sbox[idx_j];
    ks = sbox[t];
    e.out_byte  = r.value ^ ks;
    e.keystream = ks;
    e.not_keyed = 1'b0;
    return 1'b1;
  endfunction

  // drive one request after a random gap and wait for it to be taken
  task automatic send_request(input req_t r, input bit typed, input res_t want);
    res_t e;
    int gap;
    if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
    gap = send_steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    sent++;
    // result is registered in a later state, so the push is never late
    if (cipher_step(r, e)) cipher_q.push_back(typed ? want : e);
  endtask

  // random request; dropped key bytes past the store do not count
  task automatic push_item(input logic cmd, input logic [7:0] v, input logic last);
    req_t r;
    r.cmd      = cmd;
    r.value    = v;
    r.key_last = last;
    if (cmd == CMD_MSG || gen_keys < KEY_MAX) stim_count++;
    if (cmd == CMD_KEY) gen_keys = last ? 0 : gen_keys + 1;
    send_request(r, 1'b0, NO_RES);
  endtask

  // result side: random stall before each result, with stretches of none
  initial begin
    int stall;
    bit steady;
    res_ready = 1'b0;
    steady = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 39) == 0) steady = !steady;
      stall = steady ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
    end
  end

  // result checker, sampled at the edge where the handshake completes
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      results_seen++;
      if (cipher_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", res));
      end else begin
        want_res = cipher_q.pop_front();
        if (want_res.not_keyed) pass_results++;
        if (res.out_byte !== want_res.out_byte)
          report_mismatch($sformatf("out_byte %h, want %h", res.out_byte, want_res.out_byte));
        if (res.keystream !== want_res.keystream)
          report_mismatch($sformatf("keystream %h, want %h", res.keystream,
                                    want_res.keystream));
        if (res.not_keyed !== want_res.not_keyed)
          report_mismatch($sformatf("not_keyed %b, want %b", res.not_keyed,
                                    want_res.not_keyed));
      end
    end
  end

  // watchdog
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding", LIMIT_CYCLES,
             cipher_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // reset, directed table, random traffic, drain
  initial begin
    int len;
    int nmsg;
    int seq;
    int pick;
    rst         = 1'b1;
    req_valid   = 1'b0;
    req         = '0;
    key_len     = 0;
    idx_i       = 8'h00;
    idx_j       = 8'h00;
    have_key    = 1'b0;
    send_steady = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int k = 0; k < DIR_ROWS; k++)
      send_request(DIRECTED[k].rq, DIRECTED[k].typed, DIRECTED[k].want);

    // mostly well formed: a marked key then a run of message bytes,
    // first an overlong key and then one that fills the store exactly
    gen_keys   = 0;
    stim_count = 0;
    seq        = 0;
    while (stim_count < RANDOM_ITEMS) begin
      if (seq < 2 || $urandom_range(0, 99) < 85) begin
        if (seq == 0) begin
          len = KEY_MAX + 14;
        end else if (seq == 1) begin
          len = KEY_MAX;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 70) len = $urandom_range(1, 16);
          else if (pick < 90) len = $urandom_range(17, 64);
          else if (pick < 97) len = $urandom_range(65, 255);
          else len = $urandom_range(256, 290);
        end
        for (int k = 0; k < len; k++)
          push_item(CMD_KEY, 8'($urandom_range(0, 255)), k == len - 1);
        nmsg = $urandom_range(1, 40);
        repeat (nmsg)
          push_item(CMD_MSG, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        seq++;
      end else begin
        // noise: stray key bytes, early marks, lone messages
        repeat ($urandom_range(1, 4))
          push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                    $urandom_range(0, 3) == 0);
      end
    end
    req_valid <= 1'b0;

    while (cipher_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    while (cipher_q.size() != 0) begin
      want_res = cipher_q.pop_front();
      report_mismatch($sformatf("result %h never came", want_res));
    end

    $display("sent %0d requests over %0d key schedules, including overlong and full keys",
             sent, schedules);
    $display("checked %0d results, %0d of them passed through before any key",
             results_seen, pass_results);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/rc4_pkg.sv
sv/rc4_ctrl.sv
sv/rc4_dp.sv
sv/rc4_stream_cipher.sv
tb/rc4_stream_cipher_test.sv
